// File: hdl/gcsc_pkg.sv
// Shared types, codes and constants of the gripper command and stall controller.
package gcsc_pkg;

	localparam int WINDOW_LENGTH_DEF = 10;
	localparam int LINE_CAPACITY_DEF = 64;
	localparam int SAMPLE_BITS_DEF   = 12;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 12;
	localparam int THRESH_W    = 7;
	localparam int MIN_CLOSE_W = 10;
	localparam int TICK_W      = 12;
	localparam int CHAR_W      = 8;
	localparam int AVG_W       = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CLOSE  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_TICKS = 2'd2;

	localparam int                     THRESHOLD_RESET  = 44;
	localparam logic [MIN_CLOSE_W-1:0] MIN_CLOSE_RESET  = 10'd50;
	localparam logic [TICK_W-1:0]      OPEN_TICKS_RESET = 12'd125;
	localparam logic [TICK_W-1:0]      TICK_MAX         = 12'hFFF;

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_CLOSING = 2'd1;
	localparam logic [1:0] MODE_OPENING = 2'd2;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_ACK  = 2'd1;
	localparam logic [1:0] EV_DONE = 2'd2;
	localparam logic [1:0] EV_BUSY = 2'd3;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;

	typedef struct packed {
		logic eol;
		logic open_hit;
		logic close_hit;
		logic stop_hit;
	} line_cmd_t;

	function automatic logic match_open(input logic [2:0] pos, input logic [CHAR_W-1:0] c);
		logic m;
		case (pos)
			3'd0: m = (c == "O");
			3'd1: m = (c == "p");
			3'd2: m = (c == "e");
			3'd3: m = (c == "n");
			default: m = 1'b0;
		endcase
		return m;
	endfunction

	function automatic logic match_close(input logic [2:0] pos, input logic [CHAR_W-1:0] c);
		logic m;
		case (pos)
			3'd0: m = (c == "C");
			3'd1: m = (c == "l");
			3'd2: m = (c == "o");
			3'd3: m = (c == "s");
			3'd4: m = (c == "e");
			default: m = 1'b0;
		endcase
		return m;
	endfunction

	function automatic logic match_stop(input logic [2:0] pos, input logic [CHAR_W-1:0] c);
		logic m;
		case (pos)
			3'd0: m = (c == "S");
			3'd1: m = (c == "t");
			3'd2: m = (c == "o");
			3'd3: m = (c == "p");
			default: m = 1'b0;
		endcase
		return m;
	endfunction

endpackage

// File: hdl/gcsc_line.sv
// Incremental command line matcher for Open, Close and Stop.
module gcsc_line #(
	parameter int LINE_CAPACITY = gcsc_pkg::LINE_CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          char_en,
	input  logic [gcsc_pkg::CHAR_W-1:0]   char_code,
	output gcsc_pkg::line_cmd_t           cmd
);

	localparam int LEN_W = $clog2(LINE_CAPACITY);

	logic [LEN_W-1:0] len_q;
	logic [2:0]       flags_q;
	logic [2:0]       keep;
	logic [2:0]       pos;
	logic             short_pos;
	logic             has_room;

	assign short_pos = (len_q <= LEN_W'(7));
	assign pos       = len_q[2:0];
	assign has_room  = (len_q < LEN_W'(LINE_CAPACITY - 1));

	always_comb begin
		keep[0] = short_pos && gcsc_pkg::match_open(pos, char_code);
		keep[1] = short_pos && gcsc_pkg::match_close(pos, char_code);
		keep[2] = short_pos && gcsc_pkg::match_stop(pos, char_code);
	end

	always_comb begin
		cmd.eol       = (char_code == gcsc_pkg::CHAR_LF) || (char_code == gcsc_pkg::CHAR_CR);
		cmd.open_hit  = flags_q[0] && (len_q == LEN_W'(4));
		cmd.close_hit = flags_q[1] && (len_q == LEN_W'(5));
		cmd.stop_hit  = flags_q[2] && (len_q == LEN_W'(4));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			flags_q <= 3'b111;
		end else if (char_en) begin
			if (cmd.eol || !has_room) begin
				len_q   <= '0;
				flags_q <= 3'b111;
			end else begin
				len_q   <= len_q + LEN_W'(1);
				flags_q <= flags_q & keep;
			end
		end
	end

endmodule

// File: hdl/gcsc_window.sv
// Moving current window, running sum and stall threshold compare.
module gcsc_window #(
	parameter int WINDOW_LENGTH = gcsc_pkg::WINDOW_LENGTH_DEF,
	parameter int SAMPLE_BITS   = gcsc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            thr_wr,
	input  logic [gcsc_pkg::THRESH_W-1:0]   thr_value,
	input  logic                            clear,
	input  logic                            tick_en,
	input  logic [SAMPLE_BITS-1:0]          sample,
	output logic [gcsc_pkg::AVG_W-1:0]      total_next_lo,
	output logic                            over
);

	localparam int TOTAL_W   = SAMPLE_BITS + $clog2(WINDOW_LENGTH + 1);
	localparam int CMP_W     = TOTAL_W + 7;
	localparam int PW        = $clog2(WINDOW_LENGTH);
	localparam int FULL      = (1 << SAMPLE_BITS) - 1;
	localparam int RHS_SCALE = FULL * WINDOW_LENGTH;
	localparam int RHS_RESET = gcsc_pkg::THRESHOLD_RESET * RHS_SCALE;

	logic [SAMPLE_BITS-1:0]   win_q [WINDOW_LENGTH];
	logic [WINDOW_LENGTH-1:0] win_valid_q;
	logic [PW-1:0]            pos_q;
	logic [TOTAL_W-1:0]       total_q;
	logic [CMP_W-1:0]         rhs_q;
	logic [SAMPLE_BITS-1:0]   old;
	logic [TOTAL_W-1:0]       total_tick;
	logic [TOTAL_W-1:0]       total_next;
	logic [CMP_W-1:0]         lhs;

	assign old        = win_valid_q[pos_q] ? win_q[pos_q] : '0;
	assign total_tick = total_q - TOTAL_W'(old) + TOTAL_W'(sample);
	assign lhs        = CMP_W'(total_tick) * CMP_W'(100);
	assign over       = (lhs > rhs_q);

	always_comb begin
		if (clear)
			total_next = '0;
		else if (tick_en)
			total_next = total_tick;
		else
			total_next = total_q;
	end

	assign total_next_lo = gcsc_pkg::AVG_W'(total_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rhs_q <= CMP_W'(RHS_RESET);
		end else if (thr_wr) begin
			rhs_q <= CMP_W'(thr_value) * CMP_W'(RHS_SCALE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q <= '0;
			pos_q       <= '0;
			total_q     <= '0;
		end else if (clear) begin
			win_valid_q <= '0;
			pos_q       <= '0;
			total_q     <= '0;
		end else if (tick_en) begin
			win_valid_q[pos_q] <= 1'b1;
			pos_q              <= (pos_q == PW'(WINDOW_LENGTH - 1)) ? '0 : pos_q + PW'(1);
			total_q            <= total_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_en && !clear) begin
			win_q[pos_q] <= sample;
		end
	end

endmodule

// File: hdl/gripper_command_stall_controller.sv
// Top level of the gripper command and stall controller.
// Input channel (in_valid, in_stall): op selects a received character (char_code)
// or a 10 ms sample tick (current_sample). Output channel (out_valid, out_stall):
// exactly one result per input item, carrying motor_drive, led_on, event_res and
// average_sum, in input order.
// Configuration channel (cfg_valid, cfg_ready): cfg_index 0 threshold percent,
// 1 minimum close ticks, 2 open ticks; other indexes are ignored. cfg_ready is
// always high; write only while no item is in flight.
// An item passes through one input register and one result register, with the
// command and window logic between them. Throughput: one item per cycle while
// the receiver does not stall; the mode, line and window state is updated in
// the same cycle the item leaves the input register.
// Reset: motor stopped, line empty, window and sum zero, registers at defaults.
// Receiver stall: the result register holds; the input register then fills and
// in_stall rises until the result is taken.
module gripper_command_stall_controller #(
	parameter int WINDOW_LENGTH = gcsc_pkg::WINDOW_LENGTH_DEF,
	parameter int LINE_CAPACITY = gcsc_pkg::LINE_CAPACITY_DEF,
	parameter int SAMPLE_BITS   = gcsc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic [gcsc_pkg::CHAR_W-1:0]       char_code,
	input  logic [SAMPLE_BITS-1:0]            current_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        motor_drive,
	output logic                              led_on,
	output logic [1:0]                        event_res,
	output logic [gcsc_pkg::AVG_W-1:0]        average_sum,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gcsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [gcsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                               valid_s1;
	logic                               op_s1;
	logic [gcsc_pkg::CHAR_W-1:0]        char_s1;
	logic [SAMPLE_BITS-1:0]             sample_s1;
	logic                               advance;
	logic                               proc;
	logic                               cfg_wr;
	logic [gcsc_pkg::MIN_CLOSE_W-1:0]   min_close_q;
	logic [gcsc_pkg::TICK_W-1:0]        open_ticks_q;
	logic [1:0]                         mode_q;
	logic [gcsc_pkg::TICK_W-1:0]        tick_q;
	logic [1:0]                         mode_next;
	logic [gcsc_pkg::TICK_W-1:0]        tick_next;
	logic [gcsc_pkg::TICK_W-1:0]        tick_inc;
	logic [gcsc_pkg::TICK_W-1:0]        open_limit;
	logic [1:0]                         ev;
	logic                               char_en;
	logic                               win_clear;
	logic                               win_tick;
	logic                               over;
	logic [gcsc_pkg::AVG_W-1:0]         total_lo;
	gcsc_pkg::line_cmd_t                cmd;
	logic                               out_valid_q;
	logic [1:0]                         motor_drive_q;
	logic                               led_on_q;
	logic [1:0]                         event_res_q;
	logic [gcsc_pkg::AVG_W-1:0]         average_sum_q;

	assign advance   = !out_valid_q || !out_stall;
	assign proc      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_close_q  <= gcsc_pkg::MIN_CLOSE_RESET;
			open_ticks_q <= gcsc_pkg::OPEN_TICKS_RESET;
		end else if (cfg_wr) begin
			if (cfg_index == gcsc_pkg::CFG_MIN_CLOSE)
				min_close_q <= cfg_data[gcsc_pkg::MIN_CLOSE_W-1:0];
			if (cfg_index == gcsc_pkg::CFG_OPEN_TICKS)
				open_ticks_q <= cfg_data[gcsc_pkg::TICK_W-1:0];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1     <= op;
			char_s1   <= char_code;
			sample_s1 <= current_sample;
		end
	end

	assign char_en   = proc && (op_s1 == gcsc_pkg::OP_CHAR) && (mode_q == gcsc_pkg::MODE_IDLE);
	assign win_tick  = proc && (op_s1 == gcsc_pkg::OP_TICK) && (mode_q == gcsc_pkg::MODE_CLOSING);
	assign win_clear = char_en && cmd.eol && !cmd.open_hit && cmd.close_hit;

	gcsc_line #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_en  (char_en),
		.char_code(char_s1),
		.cmd      (cmd)
	);

	gcsc_window #(
		.WINDOW_LENGTH(WINDOW_LENGTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.thr_wr       (cfg_wr && (cfg_index == gcsc_pkg::CFG_THRESHOLD)),
		.thr_value    (cfg_data[gcsc_pkg::THRESH_W-1:0]),
		.clear        (win_clear),
		.tick_en      (win_tick),
		.sample       (sample_s1),
		.total_next_lo(total_lo),
		.over         (over)
	);

	assign tick_inc   = (tick_q < gcsc_pkg::TICK_MAX) ? tick_q + gcsc_pkg::TICK_W'(1) : tick_q;
	assign open_limit = (open_ticks_q == '0) ? gcsc_pkg::TICK_W'(1) : open_ticks_q;

	always_comb begin
		mode_next = mode_q;
		tick_next = tick_q;
		ev        = gcsc_pkg::EV_NONE;
		if (op_s1 == gcsc_pkg::OP_CHAR) begin
			if (mode_q != gcsc_pkg::MODE_IDLE) begin
				ev = gcsc_pkg::EV_BUSY;
			end else if (cmd.eol && cmd.open_hit) begin
				mode_next = gcsc_pkg::MODE_OPENING;
				tick_next = '0;
				ev        = gcsc_pkg::EV_ACK;
			end else if (cmd.eol && cmd.close_hit) begin
				mode_next = gcsc_pkg::MODE_CLOSING;
				tick_next = '0;
				ev        = gcsc_pkg::EV_ACK;
			end else if (cmd.eol && cmd.stop_hit) begin
				mode_next = gcsc_pkg::MODE_IDLE;
			end
		end else begin
			case (mode_q)
				gcsc_pkg::MODE_OPENING: begin
					tick_next = tick_inc;
					if (tick_inc >= open_limit) begin
						mode_next = gcsc_pkg::MODE_IDLE;
						ev        = gcsc_pkg::EV_DONE;
					end
				end
				gcsc_pkg::MODE_CLOSING: begin
					if (over && (tick_q > gcsc_pkg::TICK_W'(min_close_q))) begin
						mode_next = gcsc_pkg::MODE_IDLE;
						ev        = gcsc_pkg::EV_DONE;
					end else begin
						tick_next = tick_inc;
					end
				end
				default: begin
					mode_next = mode_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= gcsc_pkg::MODE_IDLE;
			tick_q <= '0;
		end else if (proc) begin
			mode_q <= mode_next;
			tick_q <= tick_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			motor_drive_q <= mode_next;
			led_on_q      <= (mode_next != gcsc_pkg::MODE_IDLE);
			event_res_q   <= ev;
			average_sum_q <= total_lo;
		end
	end

	assign out_valid   = out_valid_q;
	assign motor_drive = motor_drive_q;
	assign led_on      = led_on_q;
	assign event_res   = event_res_q;
	assign average_sum = average_sum_q;

endmodule
